>>> sv/hbdp_pkg.sv
// shared types and constants for the h-bridge duty to pwm level converter
// no dependencies

package hbdp_pkg;

    localparam int LEVEL_BITS     = 16;
    localparam int DUTY_BITS      = 16;
    localparam int DUTY_FRAC_BITS = 14;
    localparam int ZONE_BITS      = 15;
    localparam int CMD_BITS       = 3;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int S_TDATA_BITS   = 24;
    localparam int M_TDATA_BITS   = 32;

    localparam logic [LEVEL_BITS-1:0] WRAP_RESET = LEVEL_BITS'(1000);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SET_DUTY = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_BRAKE    = 3'd3,
        CMD_TICK     = 3'd4
    } cmd_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_WRAP_VALUE = 2'd0,
        REG_DEAD_ZONE  = 2'd1,
        REG_BIAS       = 2'd2,
        REG_DECAY_MODE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] wrap_value;
        logic [ZONE_BITS-1:0]  dead_zone;
        logic [ZONE_BITS-1:0]  bias;
        logic                  decay_mode;
    } cfg_t;

endpackage

>>> sv/hbridge_duty_to_pwm_levels.sv
// top level of the h-bridge duty to pwm level converter
// depends on hbdp_pkg, hbdp_cfg_regs and hbdp_level_calc

// Takes one command transaction per clock with no bubbles while the output
// is not stalled: a transaction enters an input register, is executed from
// there once the output register is free or being taken (dead zone and bias
// shaping, one 16x16 multiply by the wrap value, saturation and decay-mode
// mapping) and its result, if any, is registered in the output register. The
// single multiply between the input register and the pending-level registers
// sets the clock rate. Stop, brake and tick while enabled each give one result;
// set duty, start, tick while disabled and unused codes give none.
// Configuration must only be written while no transaction is in flight.

module hbridge_duty_to_pwm_levels (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [hbdp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [hbdp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // command [2:0], duty [18:3], zero fill [23:19]
    input  logic [hbdp_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // level_a [15:0], level_b [31:16]
    output logic [hbdp_pkg::M_TDATA_BITS-1:0]  m_tdata
);

    localparam int LB = hbdp_pkg::LEVEL_BITS;
    localparam int CB = hbdp_pkg::CMD_BITS;
    localparam int DB = hbdp_pkg::DUTY_BITS;

    hbdp_pkg::cfg_t cfg;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [CB-1:0]        in_cmd_reg;
    logic signed [DB-1:0] in_duty_reg;

    logic                 enabled_reg;
    logic                 enabled_next;
    logic [LB-1:0]        pending_a_reg;
    logic [LB-1:0]        pending_a_next;
    logic [LB-1:0]        pending_b_reg;
    logic [LB-1:0]        pending_b_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [LB-1:0]        out_a_reg;
    logic [LB-1:0]        out_a_next;
    logic [LB-1:0]        out_b_reg;
    logic [LB-1:0]        out_b_next;

    logic [LB-1:0]        calc_a;
    logic [LB-1:0]        calc_b;
    logic                 exec;
    logic                 produce;

    hbdp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hbdp_level_calc u_calc (
        .duty    (in_duty_reg),
        .cfg     (cfg),
        .level_a (calc_a),
        .level_b (calc_b)
    );

    assign exec     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || exec;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_comb begin
        enabled_next   = enabled_reg;
        pending_a_next = pending_a_reg;
        pending_b_next = pending_b_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        produce        = 1'b0;
        if (exec) begin
            unique case (hbdp_pkg::cmd_t'(in_cmd_reg))
                hbdp_pkg::CMD_SET_DUTY: begin
                    pending_a_next = calc_a;
                    pending_b_next = calc_b;
                end
                hbdp_pkg::CMD_START: begin
                    enabled_next = 1'b1;
                end
                hbdp_pkg::CMD_STOP: begin
                    enabled_next   = 1'b0;
                    pending_a_next = '0;
                    pending_b_next = '0;
                    out_a_next     = '0;
                    out_b_next     = '0;
                    produce        = 1'b1;
                end
                hbdp_pkg::CMD_BRAKE: begin
                    enabled_next   = 1'b0;
                    pending_a_next = '0;
                    pending_b_next = '0;
                    out_a_next     = cfg.wrap_value;
                    out_b_next     = cfg.wrap_value;
                    produce        = 1'b1;
                end
                hbdp_pkg::CMD_TICK: begin
                    if (enabled_reg) begin
                        out_a_next = pending_a_reg;
                        out_b_next = pending_b_reg;
                        produce    = 1'b1;
                    end
                end
                default: begin
                    produce = 1'b0;
                end
            endcase
        end
        if (exec) begin
            out_valid_next = produce;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            enabled_reg   <= 1'b0;
            pending_a_reg <= '0;
            pending_b_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            enabled_reg   <= enabled_next;
            pending_a_reg <= pending_a_next;
            pending_b_reg <= pending_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tdata[CB-1:0];
            in_duty_reg <= signed'(s_tdata[CB+DB-1:CB]);
        end
        out_a_reg <= out_a_next;
        out_b_reg <= out_b_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_b_reg, out_a_reg};

    a_stop_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && (in_cmd_reg == hbdp_pkg::CMD_STOP)
        |=> m_tvalid && (m_tdata == '0) && !enabled_reg)
        else $error("stop did not give a zero result");

    a_brake_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && (in_cmd_reg == hbdp_pkg::CMD_BRAKE)
        |=> (pending_a_reg == '0) && (pending_b_reg == '0) && !enabled_reg)
        else $error("brake did not clear pending levels");

    a_tick_disabled_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        exec && (in_cmd_reg == hbdp_pkg::CMD_TICK) && !enabled_reg
        |=> !m_tvalid)
        else $error("tick while disabled produced a result");

    a_stalled_output_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !exec)
        else $error("executed while a result was stalled");

endmodule

>>> sv/hbdp_cfg_regs.sv
// configuration register file: wrap value, dead zone, bias, decay mode
// depends on hbdp_pkg

module hbdp_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [hbdp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [hbdp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output hbdp_pkg::cfg_t                     cfg
);

    hbdp_pkg::cfg_t cfg_reg;
    hbdp_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (hbdp_pkg::reg_index_t'(cfg_addr))
                hbdp_pkg::REG_WRAP_VALUE: begin
                    cfg_next.wrap_value = cfg_wdata[hbdp_pkg::LEVEL_BITS-1:0];
                end
                hbdp_pkg::REG_DEAD_ZONE: begin
                    cfg_next.dead_zone = cfg_wdata[hbdp_pkg::ZONE_BITS-1:0];
                end
                hbdp_pkg::REG_BIAS: begin
                    cfg_next.bias = cfg_wdata[hbdp_pkg::ZONE_BITS-1:0];
                end
                hbdp_pkg::REG_DECAY_MODE: begin
                    cfg_next.decay_mode = cfg_wdata[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_value <= hbdp_pkg::WRAP_RESET;
            cfg_reg.dead_zone  <= '0;
            cfg_reg.bias       <= '0;
            cfg_reg.decay_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/hbdp_level_calc.sv
// duty shaping, scaling by wrap value and decay-mode level mapping
// depends on hbdp_pkg

module hbdp_level_calc (
    input  logic signed [hbdp_pkg::DUTY_BITS-1:0]  duty,
    input  hbdp_pkg::cfg_t                         cfg,
    output logic        [hbdp_pkg::LEVEL_BITS-1:0] level_a,
    output logic        [hbdp_pkg::LEVEL_BITS-1:0] level_b
);

    localparam int EXT_BITS  = hbdp_pkg::DUTY_BITS + 1;
    localparam int MAG_BITS  = hbdp_pkg::DUTY_BITS;
    localparam int PROD_BITS = MAG_BITS + hbdp_pkg::LEVEL_BITS;
    localparam int P_BITS    = PROD_BITS - hbdp_pkg::DUTY_FRAC_BITS;

    logic signed [EXT_BITS-1:0]           duty_ext;
    logic signed [EXT_BITS-1:0]           dz_ext;
    logic signed [EXT_BITS-1:0]           bs_ext;
    logic signed [EXT_BITS-1:0]           shaped;
    logic        [EXT_BITS-1:0]           mag_full;
    logic        [MAG_BITS-1:0]           mag;
    logic        [PROD_BITS-1:0]          prod;
    logic        [P_BITS-1:0]             p;
    logic        [P_BITS-1:0]             top_ext;
    logic        [P_BITS-1:0]             diff;
    logic                                 p_over;
    logic                                 is_pos;
    logic                                 is_neg;
    logic        [hbdp_pkg::LEVEL_BITS-1:0] top;
    logic        [hbdp_pkg::LEVEL_BITS-1:0] sub_sat;
    logic        [hbdp_pkg::LEVEL_BITS-1:0] min_sat;

    // dead zone and bias shaping
    always_comb begin
        duty_ext = EXT_BITS'(duty);
        dz_ext   = signed'({{(EXT_BITS-hbdp_pkg::ZONE_BITS){1'b0}}, cfg.dead_zone});
        bs_ext   = signed'({{(EXT_BITS-hbdp_pkg::ZONE_BITS){1'b0}}, cfg.bias});
        if (duty_ext > dz_ext) begin
            shaped = (duty_ext > bs_ext) ? duty_ext : bs_ext;
        end else if (duty_ext < -dz_ext) begin
            shaped = (duty_ext < -bs_ext) ? duty_ext : -bs_ext;
        end else begin
            shaped = '0;
        end
    end

    always_comb begin
        mag_full = shaped[EXT_BITS-1] ? unsigned'(-shaped) : unsigned'(shaped);
        mag      = mag_full[MAG_BITS-1:0];
        top      = cfg.wrap_value;
        prod     = {{(PROD_BITS-MAG_BITS){1'b0}}, mag}
                 * {{(PROD_BITS-hbdp_pkg::LEVEL_BITS){1'b0}}, top};
        p        = prod[PROD_BITS-1:hbdp_pkg::DUTY_FRAC_BITS];
        top_ext  = {{(P_BITS-hbdp_pkg::LEVEL_BITS){1'b0}}, top};
        p_over   = p > top_ext;
        diff     = top_ext - p;
        sub_sat  = p_over ? '0 : diff[hbdp_pkg::LEVEL_BITS-1:0];
        min_sat  = p_over ? top : p[hbdp_pkg::LEVEL_BITS-1:0];
        is_pos   = (p != '0) && !shaped[EXT_BITS-1];
        is_neg   = (p != '0) && shaped[EXT_BITS-1];
    end

    always_comb begin
        if (!cfg.decay_mode) begin
            // slow decay, idle high
            level_a = is_neg ? sub_sat : top;
            level_b = is_pos ? sub_sat : top;
        end else begin
            // fast decay, idle low
            level_a = is_pos ? min_sat : '0;
            level_b = is_neg ? min_sat : '0;
        end
    end

endmodule
